@@ rtl/eps_pkg.sv @@
// shared types and constants for the event period statistics core
`timescale 1ns / 1ps

package eps_pkg;

   localparam int CHANNELS   = 4;
   localparam int CAPACITY   = 1024 * 8;
   localparam int CH_W       = 2;
   localparam int STAMP_W    = 64;
   localparam int OUT_CNT_W  = 14;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int DIV_STEP_W = $clog2(STAMP_W);

   // request word: a mark or a read on one channel
   typedef struct packed {
      logic                 action;
      logic [CH_W-1:0]      channel;
      logic [STAMP_W-1:0]   timestamp_ns;
   } req_type;

   // response word: statistics of one closed window
   typedef struct packed {
      logic [STAMP_W-1:0]   min_period_ns;
      logic [STAMP_W-1:0]   max_period_ns;
      logic [STAMP_W-1:0]   avg_period_ns;
      logic [OUT_CNT_W-1:0] sample_count;
   } rsp_type;

   // request action codes
   localparam logic ACT_MARK = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic capture_mark;
      logic update_mark;
      logic start_read;
      logic load_rsp;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

@@ rtl/eps_divider.sv @@
// restoring divider: one quotient bit per cycle for the window average
`timescale 1ns / 1ps

module eps_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [eps_pkg::STAMP_W-1:0]   dividend,
   input  logic [eps_pkg::CNT_W-1:0]     divisor,
   output logic                          done,
   output logic [eps_pkg::STAMP_W-1:0]   quotient
);
   import eps_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [STAMP_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      div_ff, div_in;
   logic [CNT_W:0]        trial;
   logic [CNT_W:0]        diff;

   // one shift and trial subtract per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[STAMP_W-1]};
      diff    = trial - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[STAMP_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[STAMP_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_W'(STAMP_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control and data registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/eps_datapath.sv @@
// per-channel window registers, mark update, read snapshot and response register
`timescale 1ns / 1ps

module eps_datapath (
   input  logic                clock,
   input  logic                reset,
   input  eps_pkg::req_type    req_data,
   input  eps_pkg::cmd_type    cmd,
   output eps_pkg::status_type status,
   output eps_pkg::rsp_type    rsp_data
);
   import eps_pkg::*;

   localparam logic [CH_W:0] CHANNELS_N = (CH_W + 1)'(CHANNELS);
   localparam logic [CNT_W-1:0] CAPACITY_N = CNT_W'(CAPACITY);

   // channel state
   logic [STAMP_W-1:0] last_stamp_ff [CHANNELS];
   logic               has_stamp_ff  [CHANNELS];
   logic [CNT_W-1:0]   count_ff      [CHANNELS];
   logic [STAMP_W-1:0] min_ff        [CHANNELS];
   logic [STAMP_W-1:0] max_ff        [CHANNELS];
   logic [STAMP_W-1:0] sum_ff        [CHANNELS];

   // mark in flight
   logic [CH_W-1:0]    mark_ch_ff;
   logic               mark_ok_ff;
   logic [STAMP_W-1:0] mark_stamp_ff;
   logic [STAMP_W-1:0] delta_ff, delta_in;

   // read snapshot
   logic               snap_ok_ff;
   logic [CNT_W-1:0]   snap_count_ff;
   logic [STAMP_W-1:0] snap_min_ff;
   logic [STAMP_W-1:0] snap_max_ff;

   rsp_type            rsp_ff, rsp_in;
   logic               ch_ok;
   logic               div_done;
   logic [STAMP_W-1:0] quotient;

   assign ch_ok = {1'b0, req_data.channel} < CHANNELS_N;

   // delta from the channel's previous stamp, zero for the first one
   always_comb begin
      delta_in = '0;
      if (has_stamp_ff[req_data.channel])
         delta_in = req_data.timestamp_ns - last_stamp_ff[req_data.channel];
   end

   // capture the mark and the read snapshot at acceptance
   always_ff @(posedge clock) begin
      if (cmd.capture_mark) begin
         mark_ch_ff    <= req_data.channel;
         mark_ok_ff    <= ch_ok;
         mark_stamp_ff <= req_data.timestamp_ns;
         delta_ff      <= delta_in;
      end
      if (cmd.start_read) begin
         snap_ok_ff    <= ch_ok;
         snap_count_ff <= count_ff[req_data.channel];
         snap_min_ff   <= min_ff[req_data.channel];
         snap_max_ff   <= max_ff[req_data.channel];
      end
   end

   // window update on a mark, window clear on a read
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            has_stamp_ff[i] <= 1'b0;
            count_ff[i]     <= '0;
         end
      end else begin
         if (cmd.update_mark && mark_ok_ff && count_ff[mark_ch_ff] < CAPACITY_N) begin
            if (count_ff[mark_ch_ff] == '0) begin
               min_ff[mark_ch_ff] <= delta_ff;
               max_ff[mark_ch_ff] <= delta_ff;
               sum_ff[mark_ch_ff] <= delta_ff;
            end else begin
               if (delta_ff < min_ff[mark_ch_ff])
                  min_ff[mark_ch_ff] <= delta_ff;
               if (delta_ff > max_ff[mark_ch_ff])
                  max_ff[mark_ch_ff] <= delta_ff;
               sum_ff[mark_ch_ff] <= sum_ff[mark_ch_ff] + delta_ff;
            end
            count_ff[mark_ch_ff]      <= count_ff[mark_ch_ff] + 1'b1;
            last_stamp_ff[mark_ch_ff] <= mark_stamp_ff;
            has_stamp_ff[mark_ch_ff]  <= 1'b1;
         end
         if (cmd.start_read && ch_ok)
            count_ff[req_data.channel] <= '0;
      end
   end

   // average: window sum over sample count
   eps_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_read),
      .dividend (sum_ff[req_data.channel]),
      .divisor  (count_ff[req_data.channel]),
      .done     (div_done),
      .quotient (quotient)
   );

   assign status.div_done = div_done;

   // response word, all zero for an empty window
   always_comb begin
      rsp_in = '0;
      if (snap_ok_ff && snap_count_ff != '0) begin
         rsp_in.min_period_ns = snap_min_ff;
         rsp_in.max_period_ns = snap_max_ff;
         rsp_in.avg_period_ns = quotient;
         rsp_in.sample_count  = snap_count_ff[OUT_CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp)
         rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

@@ rtl/eps_ctrl.sv @@
// sequencer for marks, reads and response delivery
`timescale 1ns / 1ps

module eps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  eps_pkg::status_type status,
   output eps_pkg::cmd_type    cmd
);
   import eps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;
   logic      rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // commands to the datapath
   always_comb begin
      cmd              = '0;
      cmd.capture_mark = req_fire && req_action == ACT_MARK;
      cmd.start_read   = req_fire && req_action == ACT_READ;
      cmd.update_mark  = (state_ff == ST_MARK);
      cmd.load_rsp     = (state_ff == ST_DELIVER) && rsp_free;
   end

   // next state and output valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire)
               state_in = (req_action == ACT_READ) ? ST_DIVIDE : ST_MARK;
         end
         ST_MARK: begin
            state_in = ST_IDLE;
         end
         ST_DIVIDE: begin
            if (status.div_done)
               state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/event_period_statistics_core.sv @@
// top level of the event period statistics core
`timescale 1ns / 1ps

// Keeps min, max and average event period for each of four channels. A mark
// word has its delta to the channel's previous stamp registered at acceptance
// and folded into the window in the mark state. A read word snapshots and
// clears the window at acceptance, then waits in the divide state while the
// bit-serial divider forms the average, and then loads the response register
// in the deliver state once that register is free; the next request is taken
// once the result sits in the response register, where it waits for
// rsp_ready.

module event_period_statistics_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  eps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output eps_pkg::rsp_type rsp_data
);
   import eps_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   eps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // channel state and arithmetic
   eps_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

@@ dv/event_period_statistics_core_tb.sv @@
// testbench for the event period statistics core: directed and random marks and reads
`timescale 1ns / 1ps

module event_period_statistics_core_tb;
   import eps_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   event_period_statistics_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // predicted per-channel window state
   logic [STAMP_W-1:0] last_stamp_q [CHANNELS];
   bit                 stamp_seen   [CHANNELS];
   int unsigned        win_count    [CHANNELS];
   logic [STAMP_W-1:0] win_min      [CHANNELS];
   logic [STAMP_W-1:0] win_max      [CHANNELS];
   logic [STAMP_W-1:0] win_sum      [CHANNELS];

   // statistics words still owed by the block, oldest first
   rsp_type pending_stats [$];

   // stimulus-side clock of each channel, keeps random marks mostly in order
   logic [STAMP_W-1:0] chan_time [CHANNELS];

   int errors  = 0;
   bit no_idle = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // overall run limit
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [STAMP_W-1:0] got,
                                  input logic [STAMP_W-1:0] want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic int draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 11);
   endfunction

   // fold one accepted word into the predicted windows
   function automatic void update_period_stats(input req_type w);
      rsp_type            stats;
      logic [STAMP_W-1:0] delta;
      int                 ch;
      ch = int'(w.channel);
      if (w.action == ACT_MARK) begin
         if (ch >= CHANNELS) return;
         // full window drops the mark and keeps the old stamp
         if (win_count[ch] >= CAPACITY) return;
         delta = stamp_seen[ch] ? w.timestamp_ns - last_stamp_q[ch] : '0;
         if (win_count[ch] == 0 || delta < win_min[ch]) win_min[ch] = delta;
         if (win_count[ch] == 0 || delta > win_max[ch]) win_max[ch] = delta;
         win_sum[ch]      = win_sum[ch] + delta;
         win_count[ch]++;
         last_stamp_q[ch] = w.timestamp_ns;
         stamp_seen[ch]   = 1'b1;
      end else begin
         stats = '0;
         if (ch < CHANNELS) begin
            if (win_count[ch] > 0) begin
               stats.min_period_ns = win_min[ch];
               stats.max_period_ns = win_max[ch];
               stats.avg_period_ns = win_sum[ch] / STAMP_W'(win_count[ch]);
               stats.sample_count  = OUT_CNT_W'(win_count[ch]);
            end
            win_count[ch] = 0;
            win_min[ch]   = '0;
            win_max[ch]   = '0;
            win_sum[ch]   = '0;
         end
         pending_stats.push_back(stats);
      end
   endfunction

   // present one word and hold it until accepted; valid stays high between words when no gap is drawn
   task automatic send_word(input req_type w);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      update_period_stats(w);
   endtask

   task automatic send_mark(input int ch, input logic [STAMP_W-1:0] stamp);
      req_type w;
      w.action       = ACT_MARK;
      w.channel      = CH_W'(ch);
      w.timestamp_ns = stamp;
      send_word(w);
   endtask

   task automatic send_read(input int ch);
      req_type w;
      w.action       = ACT_READ;
      w.channel      = CH_W'(ch);
      w.timestamp_ns = {$urandom, $urandom};
      send_word(w);
   endtask

   // hold off the sender until every owed word has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_stats.size() != 0);
   endtask

   // response side: random stalls, compare each word with the oldest prediction
   initial begin
      rsp_type want;
      int      stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_stats.size() == 0) begin
            report_mismatch("word with nothing owed, count",
                            STAMP_W'(rsp_data.sample_count), '0);
         end else begin
            want = pending_stats.pop_front();
            if (rsp_data.min_period_ns !== want.min_period_ns)
               report_mismatch("min_period_ns", rsp_data.min_period_ns, want.min_period_ns);
            if (rsp_data.max_period_ns !== want.max_period_ns)
               report_mismatch("max_period_ns", rsp_data.max_period_ns, want.max_period_ns);
            if (rsp_data.avg_period_ns !== want.avg_period_ns)
               report_mismatch("avg_period_ns", rsp_data.avg_period_ns, want.avg_period_ns);
            if (rsp_data.sample_count !== want.sample_count)
               report_mismatch("sample_count", STAMP_W'(rsp_data.sample_count),
                               STAMP_W'(want.sample_count));
         end
      end
   end

   // reads of never-marked channels come back all zero
   task automatic test_empty_reads();
      for (int ch = 0; ch < CHANNELS; ch++) send_read(ch);
   endtask

   // first sample has zero delta, then ordinary periods
   task automatic test_basic_window();
      send_mark(0, 64'd100);
      send_mark(0, 64'd250);
      send_mark(0, 64'd260);
      send_mark(0, 64'd1260);
      send_read(0);
   endtask

   // zero and all-ones stamps, backwards stamp and sum wrap
   task automatic test_stamp_extremes();
      send_mark(1, 64'd0);
      send_mark(1, '1);
      send_read(1);
      // stamp going backwards wraps the delta
      send_mark(1, 64'd5);
      send_read(1);
      // two large deltas overflow the sum
      send_mark(2, 64'd0);
      send_mark(2, 64'hC000_0000_0000_0000);
      send_mark(2, 64'h8000_0000_0000_0000);
      send_read(2);
   endtask

   // last stamp survives a read, a second read sees an empty window
   task automatic test_carry_over();
      send_mark(3, 64'd1000);
      send_read(3);
      send_read(3);
      send_mark(3, 64'd1777);
      send_read(3);
   endtask

   // fill a window to capacity; marks past it are dropped with their stamps
   task automatic test_window_full();
      logic [STAMP_W-1:0] stamp;
      stamp   = 64'd5000;
      no_idle = 1'b1;
      send_read(3);
      for (int i = 0; i < CAPACITY; i++) begin
         stamp = stamp + $urandom_range(1, 300);
         send_mark(3, stamp);
      end
      for (int i = 0; i < 4; i++) send_mark(3, 64'hFFFF_0000_0000_0000 + i);
      send_read(3);
      no_idle = 1'b0;
      send_mark(3, stamp + 64'd7);
      send_read(3);
      chan_time[3] = stamp + 64'd7;
   endtask

   // mostly ordered marks with random periods, some reads, some noise
   task automatic test_random_traffic();
      int                 ch;
      int                 pick;
      logic [STAMP_W-1:0] stamp;
      for (int i = 0; i < 650; i++) begin
         if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (i == 325) wait_for_drain();
         ch   = $urandom_range(0, CHANNELS - 1);
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            send_read(ch);
         end else begin
            if (pick < 80)
               stamp = chan_time[ch] + $urandom_range(0, 5000);
            else if (pick < 93)
               stamp = chan_time[ch] + ({$urandom, $urandom} >> $urandom_range(0, 63));
            else
               stamp = {$urandom, $urandom};
            chan_time[ch] = stamp;
            send_mark(ch, stamp);
         end
      end
   endtask

   // main sequence
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         last_stamp_q[ch] = '0;
         stamp_seen[ch]   = 1'b0;
         win_count[ch]    = 0;
         win_min[ch]      = '0;
         win_max[ch]      = '0;
         win_sum[ch]      = '0;
         chan_time[ch]    = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_reads();
      test_basic_window();
      test_stamp_extremes();
      test_carry_over();
      test_window_full();
      test_random_traffic();

      // let the last divide finish and drain
      wait_for_drain();
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
